FILE: hdl/integer_to_ascii_radix_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer_to_ascii_radix block
// Immediate-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define ITAR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset
`define ITAR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITAR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ITAR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hdl/itar_pkg.sv
// ----------------------------------------------------------------------------
// itar_pkg
// Shared types, constants and the digit-to-ASCII map for integer_to_ascii_radix.
// ----------------------------------------------------------------------------
package itar_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned RadixW = 6;
  localparam int unsigned CharW  = 7;

  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(36);
  localparam logic [RadixW-1:0] RadixDec = RadixW'(10);
  localparam logic [RadixW-1:0] DigitMaxDec = RadixW'(9);
  localparam logic [RadixW-1:0] LetterOffset = RadixW'(10);

  localparam logic [CharW-1:0] CharZero  = CharW'(8'h30);
  localparam logic [CharW-1:0] CharA     = CharW'(8'h61);
  localparam logic [CharW-1:0] CharMinus = CharW'(8'h2d);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [RadixW-1:0] radix;
  } itar_in_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } itar_out_t;

  // digit 0..9 -> '0'..'9', 10..35 -> 'a'..'z'
  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] res;
    if (d > DigitMaxDec) begin
      res = CharA + CharW'(d - LetterOffset);
    end else begin
      res = CharZero + CharW'(d);
    end
    return res;
  endfunction

endpackage

FILE: hdl/itar_divider.sv
// ----------------------------------------------------------------------------
// itar_divider
// Restoring bit-serial divider: one quotient bit per cycle by a 6-bit divisor.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_macros.svh"

module itar_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_BITS-1:0]         dividend_i,
  input  logic [itar_pkg::RadixW-1:0]   divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [VALUE_BITS-1:0]         quotient_o,
  output logic [itar_pkg::RadixW-1:0]   remainder_o
);
  import itar_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_BITS);

  logic [RadixW-1:0]     rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [RadixW-1:0]     div_q, div_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [RadixW:0]       trial;
  logic [RadixW:0]       diff;
  logic                  ge;

  // one trial subtraction per cycle
  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CntW'(VALUE_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[RadixW-1:0] : trial[RadixW-1:0];
      quo_d = {quo_q[VALUE_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  `ITAR_ASSERT_IMP(a_start_idle, clk_i, rst_ni, start_i, !busy_q, "divider started while busy")
  `ITAR_ASSERT_IMP(a_rem_below, clk_i, rst_ni, done_q, rem_q < div_q, "remainder not below divisor")
  `ITAR_ASSERT_NXT(a_last_step, clk_i, rst_ni, busy_q && cnt_q == '0 && !start_i, done_q && !busy_q,
                   "divider did not finish after last step")

endmodule

FILE: hdl/itar_digit_stack.sv
// ----------------------------------------------------------------------------
// itar_digit_stack
// Digit buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itar_digit_stack #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(VALUE_BITS)-1:0]     wr_addr_i,
  input  logic [itar_pkg::RadixW-1:0]       wr_data_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(VALUE_BITS)-1:0]     rd_addr_i,
  output logic [itar_pkg::RadixW-1:0]       rd_data_o
);
  import itar_pkg::*;

  logic [RadixW-1:0] mem [VALUE_BITS];
  logic [RadixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one integer to its ASCII digits in base 2..36, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o/in_data_i carries a value and a radix
//   (clamped to 2..36). In base ten a value with its top bit set is printed as
//   '-' and its magnitude; other bases treat the value as unsigned.
//   Output channel out_valid_o/out_ready_i/out_data_o carries one character per
//   beat; last marks the final character of the string.
//   Sequence: one bit-serial division by the radix per digit, done by the shared
//   divider. Emission then reads each digit back from the buffer and loads it
//   into the output register, after a '-' sign if there is one.
//   in_ready_o is high only while no item is in work; the next item may enter
//   while the final character still waits in the output register.
//   A stalled receiver holds the output register; the sequencer waits on it.
//   Reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  itar_pkg::itar_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output itar_pkg::itar_out_t  out_data_o
);
  import itar_pkg::*;

  localparam int unsigned AddrW = $clog2(VALUE_BITS);
  localparam int unsigned CntW  = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SIGN = 5'b00100,
    S_READ = 5'b01000,
    S_LOAD = 5'b10000
  } itar_state_e;

  itar_state_e           state_q, state_d;
  logic                  neg_q, neg_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       cnt_m1;
  itar_out_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  accept;
  logic                  slot_free;
  logic [RadixW-1:0]     radix_clamp;
  logic [VALUE_BITS+ValueW-1:0] val_ext;
  logic [VALUE_BITS-1:0] val_in;
  logic                  val_neg;
  logic [VALUE_BITS-1:0] val_mag;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [RadixW-1:0]     div_rem;
  logic [RadixW-1:0]     u_divider_divisor_hold;
  logic [RadixW-1:0]     radix_q;

  logic                  stk_wr;
  logic                  stk_rd;
  logic [RadixW-1:0]     stk_data;

  // input decode: clamp radix, take magnitude for negative decimal
  always_comb begin
    if (in_data_i.radix < RadixMin) begin
      radix_clamp = RadixMin;
    end else if (in_data_i.radix > RadixMax) begin
      radix_clamp = RadixMax;
    end else begin
      radix_clamp = in_data_i.radix;
    end
  end

  assign val_ext = {{VALUE_BITS{1'b0}}, in_data_i.value};
  assign val_in  = val_ext[VALUE_BITS-1:0];
  assign val_neg = (radix_clamp == RadixDec) && val_in[VALUE_BITS-1];
  assign val_mag = val_neg ? (~val_in + 1'b1) : val_in;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign cnt_m1     = cnt_q - 1'b1;

  // sequencer
  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    cnt_d        = cnt_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    div_start    = 1'b0;
    div_dividend = div_quo;
    stk_wr       = 1'b0;
    stk_rd       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          neg_d        = val_neg;
          cnt_d        = '0;
          div_start    = 1'b1;
          div_dividend = val_mag;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          stk_wr = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (div_quo == '0) begin
            state_d = neg_q ? S_SIGN : S_READ;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_d.character = CharMinus;
          out_d.last      = 1'b0;
          out_valid_d     = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        stk_rd  = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          out_d.character = digit_char(stk_data);
          out_d.last      = (cnt_q == CntW'(1));
          out_valid_d     = 1'b1;
          cnt_d           = cnt_m1;
          state_d         = (cnt_q == CntW'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  itar_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (accept ? radix_clamp : u_divider_divisor_hold),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // radix stays for the whole item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      radix_q <= radix_clamp;
    end
  end
  assign u_divider_divisor_hold = radix_q;

  itar_digit_stack #(
    .VALUE_BITS (VALUE_BITS)
  ) u_digit_stack (
    .clk_i     (clk_i),
    .wr_en_i   (stk_wr),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (div_rem),
    .rd_en_i   (stk_rd),
    .rd_addr_i (cnt_m1[AddrW-1:0]),
    .rd_data_o (stk_data)
  );

  `ITAR_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(VALUE_BITS),
                   "digit count above capacity")
  `ITAR_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV,
                   "divider result outside division phase")
  `ITAR_ASSERT_IMP(a_load_nonempty, clk_i, rst_ni, state_q == S_LOAD || state_q == S_READ,
                   cnt_q != '0, "digit read from empty buffer")
  `ITAR_ASSERT_IMP(a_idle_div, clk_i, rst_ni, state_q == S_IDLE, !div_busy,
                   "divider busy while idle")

endmodule
